>>> rtl/core/lprd_pkg.sv
// Shared types and constants for the length-prefixed record deframer.
package lprd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W = 32;
  localparam int unsigned STATUS_W = 2;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd65536;

  localparam logic [STATUS_W-1:0] STATUS_BODY = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MALFORMED = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   rtype;
    logic [BYTE_W-1:0]   body;
    logic                last;
  } result_t;

endpackage

>>> rtl/core/lprd_in_stage.sv
// Input register stage that holds one accepted stream byte for the parser.
module lprd_in_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lprd_pkg::BYTE_W-1:0]   stream_byte,
  output lprd_pkg::item_t               item,
  input  logic                          item_take
);

  logic                        held;
  logic [lprd_pkg::BYTE_W-1:0] data;

  assign in_ready = !held || item_take;
  assign item.valid = held;
  assign item.data = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
    if (in_valid && in_ready) begin
      data <= stream_byte;
    end
  end

endmodule

>>> rtl/core/lprd_parser.sv
// Header, type and body parsing with the result register.
module lprd_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lprd_pkg::LEN_W-1:0]    cfg_data,
  input  lprd_pkg::item_t               item,
  output logic                          item_take,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lprd_pkg::result_t             result
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_TYPE   = 2'd1,
    PH_BODY   = 2'd2,
    PH_HALTED = 2'd3
  } phase_t;

  phase_t                       phase, phase_next;
  logic [1:0]                   header_count, header_count_next;
  logic [lprd_pkg::LEN_W-1:0]   length_shift, length_shift_next;
  logic [lprd_pkg::LEN_W-1:0]   bytes_remaining, bytes_remaining_next;
  logic [lprd_pkg::BYTE_W-1:0]  current_type, current_type_next;
  logic [lprd_pkg::LEN_W-1:0]   max_record_length;
  logic [lprd_pkg::LEN_W-1:0]   assembled;
  logic [lprd_pkg::LEN_W-1:0]   remaining_dec;
  logic                         emit;
  lprd_pkg::result_t            emit_result;
  logic                         slot_free;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;
  assign item_take = item.valid && slot_free;
  assign assembled = {length_shift[lprd_pkg::LEN_W-lprd_pkg::BYTE_W-1:0], item.data};
  assign remaining_dec = (bytes_remaining != '0) ?
                         bytes_remaining - lprd_pkg::LEN_W'(1) : bytes_remaining;

  always_comb begin
    phase_next = phase;
    header_count_next = header_count;
    length_shift_next = length_shift;
    bytes_remaining_next = bytes_remaining;
    current_type_next = current_type;
    emit = 1'b0;
    emit_result = '0;
    unique case (phase)
      PH_HEADER: begin
        if (header_count != 2'd3) begin
          header_count_next = header_count + 2'd1;
          length_shift_next = assembled;
        end else begin
          header_count_next = 2'd0;
          length_shift_next = '0;
          if (assembled == '0 || assembled > max_record_length) begin
            phase_next = PH_HALTED;
            emit = 1'b1;
            emit_result.status = lprd_pkg::STATUS_MALFORMED;
            emit_result.last = 1'b1;
          end else begin
            bytes_remaining_next = assembled - lprd_pkg::LEN_W'(1);
            phase_next = PH_TYPE;
          end
        end
      end
      PH_TYPE: begin
        current_type_next = item.data;
        if (bytes_remaining == '0) begin
          phase_next = PH_HEADER;
          emit = 1'b1;
          emit_result.status = lprd_pkg::STATUS_EMPTY;
          emit_result.rtype = item.data;
          emit_result.last = 1'b1;
        end else begin
          phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        bytes_remaining_next = remaining_dec;
        emit = 1'b1;
        emit_result.status = lprd_pkg::STATUS_BODY;
        emit_result.rtype = current_type;
        emit_result.body = item.data;
        if (remaining_dec == '0) begin
          phase_next = PH_HEADER;
          emit_result.last = 1'b1;
        end
      end
      PH_HALTED: begin
        phase_next = PH_HALTED;
      end
      default: begin
        phase_next = PH_HALTED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      header_count <= 2'd0;
      length_shift <= '0;
      bytes_remaining <= '0;
      current_type <= '0;
      max_record_length <= lprd_pkg::MAX_LEN_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_record_length <= cfg_data;
      end
      if (item_take) begin
        phase <= phase_next;
        header_count <= header_count_next;
        length_shift <= length_shift_next;
        bytes_remaining <= bytes_remaining_next;
        current_type <= current_type_next;
      end
      if (slot_free) begin
        out_valid <= item_take && emit;
      end
    end
    if (slot_free && item_take && emit) begin
      result <= emit_result;
    end
  end

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALTED |=> phase == PH_HALTED)
    else $error("Parser left the halted phase without a reset.");

  a_malformed_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.status == lprd_pkg::STATUS_MALFORMED |->
      result.last && result.rtype == '0 && result.body == '0)
    else $error("Malformed result carries a type, a body byte or no last mark.");

  a_status_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result.status == lprd_pkg::STATUS_BODY ||
      result.status == lprd_pkg::STATUS_EMPTY ||
      result.status == lprd_pkg::STATUS_MALFORMED)
    else $error("Result carries an undefined status code.");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.status == lprd_pkg::STATUS_EMPTY |->
      result.last && result.body == '0)
    else $error("Empty-body result is not marked last or carries data.");

  a_header_count_idle: assert property (@(posedge clk) disable iff (rst)
    phase != PH_HEADER |-> header_count == 2'd0)
    else $error("Header byte count is nonzero outside the header phase.");

endmodule

>>> rtl/core/length_prefixed_record_deframer_top.sv
// Bytes pass the input register; results pass the result register. Throughput: one
// byte per cycle unless out_ready stalls a pending result; the input register and the
// result register each take a new transfer in the cycle the previous one moves on.
// Reset (rst, synchronous): the parser returns to the header phase with all counts
// cleared, both stages empty, and the maximum length register at 65536.
// After a malformed length the parser discards all bytes until the next reset.
module length_prefixed_record_deframer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lprd_pkg::LEN_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lprd_pkg::BYTE_W-1:0]     stream_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lprd_pkg::STATUS_W-1:0]   result_status,
  output logic [lprd_pkg::BYTE_W-1:0]     record_type,
  output logic [lprd_pkg::BYTE_W-1:0]     body_byte,
  output logic                            last_of_record
);

  lprd_pkg::item_t   item;
  logic              item_take;
  lprd_pkg::result_t result;

  lprd_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_byte (stream_byte),
    .item        (item),
    .item_take   (item_take)
  );

  lprd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .item      (item),
    .item_take (item_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign result_status = result.status;
  assign record_type = result.rtype;
  assign body_byte = result.body;
  assign last_of_record = result.last;

endmodule
